// File: rtl/core/sha1h_pkg.sv
// shared types, constants and helpers of the sha-1 hash block
package sha1h_pkg;

   localparam int WORD_W    = 32;
   localparam int WORDS     = 16;
   localparam int WIDX_W    = 4;
   localparam int NUM_RD    = 4;
   localparam int ROUNDS    = 80;
   localparam int RND_W     = 7;
   localparam int DIG_WORDS = 5;
   localparam int DIG_IDX_W = 3;
   localparam int CNT_W     = 61;

   typedef logic [WORD_W-1:0]                word_type;
   typedef logic [WIDX_W-1:0]                widx_type;
   typedef logic [RND_W-1:0]                 rnd_type;
   typedef logic [CNT_W-1:0]                 count_type;
   typedef logic [DIG_WORDS-1:0][WORD_W-1:0] digest_type;
   typedef logic [NUM_RD-1:0][WIDX_W-1:0]    raddr_type;
   typedef logic [NUM_RD-1:0][WORD_W-1:0]    rdata_type;

   // control from the sequencer to the round datapath
   typedef struct packed {
      logic    load;
      logic    round;
      logic    add;
      logic    init;
      rnd_type rnd;
   } sha1h_ctrl_type;

   localparam digest_type H_INIT = digest_type'{
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam word_type K_00_19 = 32'h5a827999;
   localparam word_type K_20_39 = 32'h6ed9eba1;
   localparam word_type K_40_59 = 32'h8f1bbcdc;
   localparam word_type K_60_79 = 32'hca62c1d6;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam widx_type   LEN_HI_IDX = 4'd14;
   localparam widx_type   LEN_LO_IDX = 4'd15;

   // big-endian byte insert; lane 0 overwrites the whole word
   function automatic word_type lane_merge(word_type w, logic [7:0] b, logic [1:0] lane);
      word_type r;
      unique case (lane)
         2'd0: r = {b, 24'h000000};
         2'd1: r = {w[31:24], b, 16'h0000};
         2'd2: r = {w[31:16], b, 8'h00};
         2'd3: r = {w[31:8], b};
         default: r = {b, 24'h000000};
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/sha1h_if.sv
// valid/ready channel interfaces for requests and digest words
interface sha1h_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha1h_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/core/sha1_hash.sv
// sha-1 hash over a byte stream, top level with sequencer and byte packing
//
//  channel  dir  payload                               handshake
//  req      in   data_byte[8], has_byte, last          valid/ready
//  rsp      out  digest_word[32], word_index[3],       valid/ready
//                last_word
//
//  a request is only accepted in the idle state, never during compression,
//  padding or digest output; a full 64-byte block runs through the compression
//  loop: a read-ahead prime state, 80 rounds at one per cycle out of the
//  message word memory, then one add
//  after last: up to 16 padding writes and a compression, twice when the length
//  does not fit, then five digest words, one per rsp handshake
//  synchronous reset restores the initial chaining values and a zero count
//  a stalled rsp holds the current word; no request is taken meanwhile
module sha1_hash (
   input logic         clock,
   input logic         reset,
   sha1h_req_if.sink   req_ch,
   sha1h_rsp_if.source rsp_ch
);
   import sha1h_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIME = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_FILL  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]             state_ff, state_in;
   rnd_type                rnd_ff, rnd_in;
   widx_type               fill_ff, fill_in;
   logic [DIG_IDX_W-1:0]   out_ff, out_in;
   logic                   first_ff, first_in;   // next fill write carries the 0x80 byte
   logic                   len_ff, len_in;       // this fill pass ends with the bit length
   logic                   fin_ff, fin_in;       // compression in flight is the final one
   logic                   pad_ff, pad_in;       // padding under way
   logic                   lpend_ff, lpend_in;   // last seen on a block-ending byte
   count_type              count_ff, count_in;
   word_type               word_ff, word_in;

   logic                   req_fire, rsp_fire;
   count_type              count_inc;
   word_type               byte_word;
   widx_type               rd_base;
   raddr_type              rd_addr;
   rdata_type              rd_data;
   logic                   mem_we;
   widx_type               mem_waddr;
   word_type               mem_wdata;
   word_type               sched_word;
   digest_type             digest;
   sha1h_ctrl_type         ctrl;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   assign count_inc = count_ff + CNT_W'(1);
   assign byte_word = lane_merge(word_ff, req_ch.data_byte, count_ff[1:0]);

   // read one round ahead: entries s, s+13, s+8 and s+2 of the 16-word window
   assign rd_base    = (state_ff == ST_ROUND) ? (rnd_ff[WIDX_W-1:0] + WIDX_W'(1)) : '0;
   assign rd_addr[0] = rd_base;
   assign rd_addr[1] = rd_base + WIDX_W'(13);
   assign rd_addr[2] = rd_base + WIDX_W'(8);
   assign rd_addr[3] = rd_base + WIDX_W'(2);

   always_comb begin
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      fill_in   = fill_ff;
      out_in    = out_ff;
      first_in  = first_ff;
      len_in    = len_ff;
      fin_in    = fin_ff;
      pad_in    = pad_ff;
      lpend_in  = lpend_ff;
      count_in  = count_ff;
      word_in   = word_ff;
      mem_we    = 1'b0;
      mem_waddr = fill_ff;
      mem_wdata = '0;

      ctrl.load  = (state_ff == ST_PRIME);
      ctrl.round = (state_ff == ST_ROUND);
      ctrl.add   = (state_ff == ST_ADD);
      ctrl.init  = 1'b0;
      ctrl.rnd   = rnd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.has_byte) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[5:2];
                  mem_wdata = byte_word;
                  word_in   = byte_word;
                  count_in  = count_inc;
               end
               priority if (req_ch.has_byte && (count_ff[5:0] == 6'd63)) begin
                  // block full: compress first, pad afterwards if last came along
                  state_in = ST_PRIME;
                  lpend_in = req_ch.last;
               end else if (req_ch.last) begin
                  state_in = ST_FILL;
                  pad_in   = 1'b1;
                  first_in = 1'b1;
                  fill_in  = count_in[5:2];
                  len_in   = !(count_in[5] && count_in[4] && count_in[3]);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PRIME: begin
            state_in = ST_ROUND;
            rnd_in   = '0;
         end
         ST_ROUND: begin
            if (rnd_ff >= RND_W'(16)) begin
               mem_we    = 1'b1;
               mem_waddr = rnd_ff[WIDX_W-1:0];
               mem_wdata = sched_word;
            end
            if (rnd_ff == RND_W'(ROUNDS - 1)) begin
               state_in = ST_ADD;
               rnd_in   = '0;
            end else begin
               rnd_in = rnd_ff + RND_W'(1);
            end
         end
         ST_ADD: begin
            priority if (fin_ff) begin
               state_in = ST_OUT;
               out_in   = '0;
               fin_in   = 1'b0;
               pad_in   = 1'b0;
            end else if (pad_ff) begin
               // length did not fit: second block of zeros and length
               state_in = ST_FILL;
               fill_in  = '0;
               first_in = 1'b0;
               len_in   = 1'b1;
            end else if (lpend_ff) begin
               state_in = ST_FILL;
               lpend_in = 1'b0;
               pad_in   = 1'b1;
               first_in = 1'b1;
               fill_in  = count_ff[5:2];
               len_in   = !(count_ff[5] && count_ff[4] && count_ff[3]);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_ff;
            priority if (first_ff) begin
               mem_wdata = lane_merge(word_ff, PAD_BYTE, count_ff[1:0]);
            end else if (len_ff && (fill_ff == LEN_HI_IDX)) begin
               mem_wdata = count_ff[CNT_W-1:CNT_W-WORD_W];
            end else if (len_ff && (fill_ff == LEN_LO_IDX)) begin
               mem_wdata = {count_ff[CNT_W-WORD_W-1:0], 3'b000};
            end else begin
               mem_wdata = '0;
            end
            first_in = 1'b0;
            if (fill_ff == LEN_LO_IDX) begin
               state_in = ST_PRIME;
               fin_in   = len_ff;
            end else begin
               fill_in = fill_ff + WIDX_W'(1);
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (out_ff == DIG_IDX_W'(DIG_WORDS - 1)) begin
                  ctrl.init = 1'b1;
                  count_in  = '0;
                  state_in  = ST_IDLE;
               end else begin
                  out_in = out_ff + DIG_IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         fill_ff  <= '0;
         out_ff   <= '0;
         first_ff <= 1'b0;
         len_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         lpend_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         fill_ff  <= fill_in;
         out_ff   <= out_in;
         first_ff <= first_in;
         len_ff   <= len_in;
         fin_ff   <= fin_in;
         pad_ff   <= pad_in;
         lpend_ff <= lpend_in;
         count_ff <= count_in;
      end
   end

   // partial word being packed, no reset needed
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   sha1h_wmem u_wmem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sha1h_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .rd_data    (rd_data),
      .sched_word (sched_word),
      .digest     (digest)
   );

   assign rsp_ch.valid       = (state_ff == ST_OUT);
   assign rsp_ch.digest_word = digest[out_ff];
   assign rsp_ch.word_index  = out_ff;
   assign rsp_ch.last_word   = (out_ff == DIG_IDX_W'(DIG_WORDS - 1));

   // schedule write-back never hits an entry read ahead for the next round
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && mem_we) |->
         (mem_waddr != rd_addr[0]) && (mem_waddr != rd_addr[1]) &&
         (mem_waddr != rd_addr[2]) && (mem_waddr != rd_addr[3]))
      else $error("schedule write clashes with read-ahead");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == RND_W'(ROUNDS - 1)) |=> (state_ff == ST_ADD))
      else $error("compression did not end after the last round");

   a_digest_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_word) |=> (state_ff == ST_IDLE) && (count_ff == '0) &&
         (digest == H_INIT))
      else $error("state not restored after the final digest word");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff < RND_W'(ROUNDS)))
      else $error("round counter out of range");

endmodule

// File: rtl/core/sha1h_wmem.sv
// message word memory, duplicated banks give four registered reads per cycle
module sha1h_wmem (
   input  logic                clock,
   input  logic                wr_en,
   input  sha1h_pkg::widx_type wr_addr,
   input  sha1h_pkg::word_type wr_data,
   input  sha1h_pkg::raddr_type rd_addr,
   output sha1h_pkg::rdata_type rd_data
);
   import sha1h_pkg::*;

   word_type  bank_a [WORDS];
   word_type  bank_b [WORDS];
   rdata_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_a[wr_addr] <= wr_data;
         bank_b[wr_addr] <= wr_data;
      end
      rd_data_ff[0] <= bank_a[rd_addr[0]];
      rd_data_ff[1] <= bank_a[rd_addr[1]];
      rd_data_ff[2] <= bank_b[rd_addr[2]];
      rd_data_ff[3] <= bank_b[rd_addr[3]];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sha1h_round.sv
// round datapath: working variables, chaining values and schedule word
module sha1h_round (
   input  logic                      clock,
   input  logic                      reset,
   input  sha1h_pkg::sha1h_ctrl_type ctrl,
   input  sha1h_pkg::rdata_type      rd_data,
   output sha1h_pkg::word_type       sched_word,
   output sha1h_pkg::digest_type     digest
);
   import sha1h_pkg::*;

   digest_type var_ff, var_in;
   digest_type h_ff, h_in;
   word_type   mix, f, k, t;

   always_comb begin
      mix = rd_data[0] ^ rd_data[1] ^ rd_data[2] ^ rd_data[3];
      if (ctrl.rnd < RND_W'(16)) begin
         sched_word = rd_data[0];
      end else begin
         sched_word = {mix[30:0], mix[31]};
      end

      // var index 0..4 is a..e
      priority if (ctrl.rnd < RND_W'(20)) begin
         f = (var_ff[1] & var_ff[2]) | (~var_ff[1] & var_ff[3]);
         k = K_00_19;
      end else if (ctrl.rnd < RND_W'(40)) begin
         f = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k = K_20_39;
      end else if (ctrl.rnd < RND_W'(60)) begin
         f = (var_ff[1] & var_ff[2]) | (var_ff[1] & var_ff[3]) | (var_ff[2] & var_ff[3]);
         k = K_40_59;
      end else begin
         f = var_ff[1] ^ var_ff[2] ^ var_ff[3];
         k = K_60_79;
      end
      t = {var_ff[0][26:0], var_ff[0][31:27]} + f + var_ff[4] + k + sched_word;

      var_in = var_ff;
      if (ctrl.load) begin
         var_in = h_ff;
      end else if (ctrl.round) begin
         var_in[4] = var_ff[3];
         var_in[3] = var_ff[2];
         var_in[2] = {var_ff[1][1:0], var_ff[1][31:2]};
         var_in[1] = var_ff[0];
         var_in[0] = t;
      end

      h_in = h_ff;
      if (ctrl.init) begin
         h_in = H_INIT;
      end else if (ctrl.add) begin
         for (int i = 0; i < DIG_WORDS; i++) begin
            h_in[i] = h_ff[i] + var_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= H_INIT;
      end else begin
         h_ff <= h_in;
      end
   end

   assign digest = h_ff;

endmodule

// File: dv/sha1h_tb_pkg.sv
// digest scoreboard for the sha-1 hash testbench: hash state, expected words, checks
`timescale 1ns / 100ps
package sha1h_tb_pkg;

   typedef struct {
      bit [31:0] word;
      bit [2:0]  index;
      bit        last;
   } digest_word_type;

   class digest_scoreboard;
      bit [31:0]       chain[5];
      bit [31:0]       blk[16];
      bit [60:0]       nbytes;
      digest_word_type digest_q[$];

      int errors;
      int messages;
      int empty_messages;
      int extra_pad_blocks;
      int total_bytes;
      int words_checked;
      int longest;

      function new();
         errors           = 0;
         messages         = 0;
         empty_messages   = 0;
         extra_pad_blocks = 0;
         total_bytes      = 0;
         words_checked    = 0;
         longest          = 0;
         foreach (blk[i]) blk[i] = '0;
         restart();
      endfunction

      function void restart();
         chain[0] = 32'h67452301;
         chain[1] = 32'hefcdab89;
         chain[2] = 32'h98badcfe;
         chain[3] = 32'h10325476;
         chain[4] = 32'hc3d2e1f0;
         nbytes   = '0;
      endfunction

      function bit [31:0] rotl(bit [31:0] x, int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      // big-endian placement, first byte of a word clears the rest of it
      function void put_byte(int pos, bit [7:0] b);
         int wi;
         int sh;
         wi = (pos >> 2) & 15;
         sh = 24 - 8 * (pos & 3);
         if ((pos & 3) == 0)
            blk[wi] = {b, 24'h000000};
         else
            blk[wi] = (blk[wi] & ~(32'hff << sh)) | (32'(b) << sh);
      endfunction

      function void compress();
         bit [31:0] v[5];
         bit [31:0] w;
         bit [31:0] f;
         bit [31:0] k;
         bit [31:0] t;
         int        s;
         foreach (v[i]) v[i] = chain[i];
         for (int r = 0; r < 80; r++) begin
            s = r & 15;
            if (r >= 16) begin
               w = rotl(blk[(s + 13) & 15] ^ blk[(s + 8) & 15] ^ blk[(s + 2) & 15] ^ blk[s], 1);
               blk[s] = w;
            end else begin
               w = blk[s];
            end
            if (r < 20) begin
               f = (v[1] & v[2]) | (~v[1] & v[3]);
               k = 32'h5a827999;
            end else if (r < 40) begin
               f = v[1] ^ v[2] ^ v[3];
               k = 32'h6ed9eba1;
            end else if (r < 60) begin
               f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
               k = 32'h8f1bbcdc;
            end else begin
               f = v[1] ^ v[2] ^ v[3];
               k = 32'hca62c1d6;
            end
            t = rotl(v[0], 5) + f + v[4] + k + w;
            v[4] = v[3];
            v[3] = v[2];
            v[2] = rotl(v[1], 30);
            v[1] = v[0];
            v[0] = t;
         end
         foreach (chain[i]) chain[i] = chain[i] + v[i];
      endfunction

      // one accepted request; a last request queues the five digest words
      function void note_request(bit [7:0] b, bit has_byte, bit last);
         int              pos;
         bit [63:0]       bit_len;
         digest_word_type item;
         if (has_byte) begin
            pos = int'(nbytes[5:0]);
            put_byte(pos, b);
            nbytes = nbytes + 1;
            total_bytes++;
            if (pos == 63) compress();
         end
         if (!last) return;
         if (nbytes == 0) empty_messages++;
         if (int'(nbytes) > longest) longest = int'(nbytes);
         pos = int'(nbytes[5:0]);
         put_byte(pos, 8'h80);
         for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
         if (pos >= 56) begin
            compress();
            foreach (blk[i]) blk[i] = '0;
            extra_pad_blocks++;
         end
         bit_len = {nbytes, 3'b000};
         blk[14] = bit_len[63:32];
         blk[15] = bit_len[31:0];
         compress();
         for (int i = 0; i < 5; i++) begin
            item = '{word: chain[i], index: 3'(i), last: (i == 4)};
            digest_q.insert(digest_q.size(), item);
         end
         messages++;
         restart();
      endfunction

      function void check_word(bit [31:0] word, bit [2:0] index, bit last);
         digest_word_type exp_w;
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %0b",
                     $time, word, index, last);
            errors++;
            return;
         end
         exp_w = digest_q.pop_front();
         words_checked++;
         if (word !== exp_w.word) begin
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, exp_w.word, word);
            errors++;
         end
         if (index !== exp_w.index) begin
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, exp_w.index, index);
            errors++;
         end
         if (last !== exp_w.last) begin
            $display("%0t: last_word mismatch: expected %0b, actual %0b",
                     $time, exp_w.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return digest_q.size();
      endfunction
   endclass

endpackage

// File: dv/tb_sha1_hash.sv
// top-level testbench of the sha-1 hash block: stimulus, idling, monitors and verdict
`timescale 1ns / 100ps
module tb_sha1_hash;
   import sha1h_tb_pkg::*;

   localparam int IDLE_LIMIT   = 3000;  // cycles with no handshake at all
   localparam int LONG_HOLD    = 700;   // one long receiver stall
   localparam int HOLD_AFTER   = 25;    // digest words seen before that stall
   localparam int RANDOM_ITEMS = 145;
   localparam int SETTLE       = 200;

   logic clock;
   logic reset;

   sha1h_req_if req_ch ();
   sha1h_rsp_if rsp_ch ();

   sha1_hash dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   digest_scoreboard sb;

   int  words_taken = 0;
   int  random_items = 0;
   int  hold_cycles = 0;
   bit  calm = 1'b0;         // no sender gaps for the current message

   // 8 ns clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // gap length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // message lengths biased to the padding boundaries
   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 6);
      if (r < 82) return $urandom_range(7, 30);
      case ($urandom_range(0, 7))
         0: return 55;
         1: return 56;
         2: return 57;
         3: return 63;
         4: return 64;
         5: return 65;
         6: return 119;
         default: return 120;
      endcase
   endfunction

   // drive one request from a falling edge and hold it until it is taken
   task automatic send_request(input bit [7:0] b, input bit has_byte, input bit last);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.has_byte  <= has_byte;
      req_ch.last      <= last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding digest word
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // random message, optionally with ignored empty requests mixed in
   task automatic send_message(input int len, input bit noisy);
      bit last_on_byte;
      last_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            random_items++;
         end
         send_request(8'($urandom_range(0, 255)), 1'b1, last_on_byte && (i == len - 1));
         random_items++;
      end
      // closing request with no byte, its data must be ignored
      if (!last_on_byte) begin
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         random_items++;
      end
   endtask

   // monitors: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.data_byte, req_ch.has_byte, req_ch.last);
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_word(rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
            words_taken++;
         end
      end
   end

   // receiver: bursts of ready, random gaps, one long stall while requests keep coming
   initial begin : receiver
      int burst;
      int gap;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (!held && words_taken >= HOLD_AFTER && req_ch.valid) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) begin
               @(negedge clock);
               hold_cycles++;
            end
         end
         rsp_ch.ready <= 1'b1;
         // occasionally a long stretch with no back-pressure
         burst = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 8);
         repeat (burst) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("%0t: no handshake for %0d cycles, %0d digest words outstanding",
               $time, IDLE_LIMIT, sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

   // main sequence
   initial begin
      sb = new();
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.has_byte  = 1'b0;
      req_ch.last      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty message: a lone last with no byte
      send_request(8'h00, 1'b0, 1'b1);
      // short text message, last on the final byte
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      // empty requests mixed in, byte extremes, last with no byte
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h3c, 1'b0, 1'b1);
      // single all-ones byte carrying last
      send_request(8'hff, 1'b1, 1'b1);
      // ignored data between bytes, then last on a byte
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hff, 1'b1, 1'b0);
      send_request(8'h7e, 1'b0, 1'b0);
      send_request(8'h81, 1'b1, 1'b1);
      // sender waits for every digest word before the random part
      drain_results();

      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 6) == 0) drain_results();
         calm = ($urandom_range(0, 4) == 0);
         send_message(pick_length(), 1'b1);
      end
      calm = 1'b0;

      drain_results();
      repeat (SETTLE) @(negedge clock);

      if (sb.pending() != 0) begin
         $display("%0t: %0d digest words never arrived", $time, sb.pending());
         sb.errors++;
      end
      $display("run covered %0d messages (%0d empty, %0d with a spill block), %0d bytes",
               sb.messages, sb.empty_messages, sb.extra_pad_blocks, sb.total_bytes);
      $display("%0d digest words checked, longest message %0d bytes, receiver stall %0d cycles",
               sb.words_checked, sb.longest, hold_cycles);
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
